### design/ntre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntre_pkg
// shared types and constants of the ndef text record extractor
// ----------------------------------------------------------------------------
package ntre_pkg;

	localparam logic [1:0] ST_TEXT     = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTTEXT  = 2'd2;
	localparam logic [1:0] ST_LANGLONG = 2'd3;

	localparam logic [7:0] TEXT_TYPE  = 8'h54;
	localparam logic [2:0] TNF_WKNOWN = 3'd1;
	localparam logic [5:0] LANG_MASK  = 6'd63;

	typedef struct packed {
		logic [7:0] text_byte;
		logic [1:0] status;
		logic       is_last;
		logic       truncated;
	} result_t;

endpackage

### design/ntre_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntre_parser
// front part: walks the record header and emits classified results
// ----------------------------------------------------------------------------
module ntre_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_start,
	input  logic [7:0]          in_byte,
	input  logic [15:0]         max_text_bytes,
	output logic                res_valid,
	output ntre_pkg::result_t   res
);
	import ntre_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_TLEN, PH_PLEN, PH_IDLEN, PH_TYPE, PH_ID,
		PH_STATUS, PH_LANG, PH_TEXT, PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic        sr_q, il_q, txt_q;
	logic [2:0]  tnf_q;
	logic [7:0]  tlen_q, idlen_q;
	logic [31:0] plen_q, left_q;
	logic [15:0] emit_q;

	logic [31:0] left_dec, plen_dec, plen_new;
	logic [5:0]  lang;
	logic [15:0] emit_inc, lim;
	logic        type_first, hdr_txt, hdr_ok;

	assign left_dec = left_q - 32'd1;
	assign plen_dec = plen_q - 32'd1;
	assign lang     = in_byte[5:0] & LANG_MASK;
	assign plen_new = plen_q - 32'd1 - {26'd0, lang};
	assign emit_inc = emit_q + 16'd1;
	assign lim      = (max_text_bytes == 16'd0) ? 16'd1 : max_text_bytes;

	// text type check sees the first type byte in the cycle it arrives
	assign type_first = (phase_q == PH_TYPE) && (left_q == {24'd0, tlen_q});
	assign hdr_txt    = type_first ? ((in_byte == TEXT_TYPE) && (tlen_q == 8'd1)) : txt_q;
	assign hdr_ok     = (plen_q != 32'd0) && (tnf_q == TNF_WKNOWN) && hdr_txt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sr_q <= 1'b0; il_q <= 1'b0; txt_q <= 1'b0; tnf_q <= '0;
			tlen_q <= '0; idlen_q <= '0; plen_q <= '0; left_q <= '0; emit_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
		end else begin
			res_valid <= 1'b0;
			if (in_valid) begin
				if (in_start) begin
					sr_q <= in_byte[4]; il_q <= in_byte[3]; tnf_q <= in_byte[2:0];
					tlen_q <= '0; plen_q <= '0; idlen_q <= '0; txt_q <= 1'b0;
					left_q <= '0; emit_q <= '0;
					phase_q <= PH_TLEN;
				end else begin
					unique case (phase_q)
						PH_TLEN: begin
							tlen_q <= in_byte;
							left_q <= sr_q ? 32'd1 : 32'd4;
							phase_q <= PH_PLEN;
						end
						PH_PLEN: begin
							plen_q <= {plen_q[23:0], in_byte};
							left_q <= left_dec;
							if (left_dec == 32'd0) begin
								if (il_q) phase_q <= PH_IDLEN;
								else if (tlen_q != 8'd0) begin
									phase_q <= PH_TYPE;
									left_q <= {24'd0, tlen_q};
								end else begin
									phase_q <= PH_DONE;
									res_valid <= 1'b1;
									res <= '{8'd0, ST_NOTTEXT, 1'b1, 1'b0};
								end
							end
						end
						PH_IDLEN: begin
							idlen_q <= in_byte;
							if (tlen_q != 8'd0) begin
								phase_q <= PH_TYPE;
								left_q <= {24'd0, tlen_q};
							end else if (in_byte != 8'd0) begin
								phase_q <= PH_ID;
								left_q <= {24'd0, in_byte};
							end else begin
								phase_q <= PH_DONE;
								res_valid <= 1'b1;
								res <= '{8'd0, ST_NOTTEXT, 1'b1, 1'b0};
							end
						end
						PH_TYPE: begin
							if (type_first) txt_q <= hdr_txt;
							left_q <= left_dec;
							if (left_dec == 32'd0) begin
								if (idlen_q != 8'd0) begin
									phase_q <= PH_ID;
									left_q <= {24'd0, idlen_q};
								end else if (hdr_ok) phase_q <= PH_STATUS;
								else begin
									phase_q <= PH_DONE;
									res_valid <= 1'b1;
									res <= '{8'd0, ST_NOTTEXT, 1'b1, 1'b0};
								end
							end
						end
						PH_ID: begin
							left_q <= left_dec;
							if (left_dec == 32'd0) begin
								if (hdr_ok) phase_q <= PH_STATUS;
								else begin
									phase_q <= PH_DONE;
									res_valid <= 1'b1;
									res <= '{8'd0, ST_NOTTEXT, 1'b1, 1'b0};
								end
							end
						end
						PH_STATUS: begin
							if ({26'd0, lang} + 32'd1 > plen_q) begin
								phase_q <= PH_DONE;
								res_valid <= 1'b1;
								res <= '{8'd0, ST_LANGLONG, 1'b1, 1'b0};
							end else begin
								plen_q <= plen_new;
								if (lang != 6'd0) begin
									left_q <= {26'd0, lang};
									phase_q <= PH_LANG;
								end else if (plen_new == 32'd0) begin
									phase_q <= PH_DONE;
									res_valid <= 1'b1;
									res <= '{8'd0, ST_EMPTY, 1'b1, 1'b0};
								end else phase_q <= PH_TEXT;
							end
						end
						PH_LANG: begin
							left_q <= left_dec;
							if (left_dec == 32'd0) begin
								if (plen_q == 32'd0) begin
									phase_q <= PH_DONE;
									res_valid <= 1'b1;
									res <= '{8'd0, ST_EMPTY, 1'b1, 1'b0};
								end else phase_q <= PH_TEXT;
							end
						end
						PH_TEXT: begin
							plen_q <= plen_dec;
							emit_q <= emit_inc;
							res_valid <= 1'b1;
							if (plen_dec == 32'd0) begin
								phase_q <= PH_DONE;
								res <= '{in_byte, ST_TEXT, 1'b1, 1'b0};
							end else if (emit_inc >= lim) begin
								phase_q <= PH_DONE;
								res <= '{in_byte, ST_TEXT, 1'b1, 1'b1};
							end else begin
								res <= '{in_byte, ST_TEXT, 1'b0, 1'b0};
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

### design/ntre_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntre_fifo
// short result queue between parser and output
// ----------------------------------------------------------------------------
module ntre_fifo #(
	parameter int Depth = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ntre_pkg::result_t wr_data,
	output logic [$clog2(Depth+1)-1:0] count,
	output logic              rd_valid,
	input  logic              rd_en,
	output ntre_pkg::result_t rd_data
);
	import ntre_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	result_t         mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;

	assign count    = cnt_q;
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			if (rd_en) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + CW'(wr_en) - CW'(rd_en);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CW'(Depth)) |-> !wr_en || rd_en)
		else $error("fifo overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> cnt_q != '0) else $error("fifo underflow");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("fifo count step");

endmodule

### design/ndef_text_record_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndef_text_record_extractor
// extracts text bytes from ndef well-known text records
// ----------------------------------------------------------------------------
// s_axis carries one record byte per transaction: tdata is data_byte,
// tuser is start_of_record. m_axis returns at most one result per input
// transaction: tdata = {truncated, status, text_byte} from bit 0 up in the
// order text_byte[7:0], status[9:8], truncated[10]; tlast is is_last.
// cfg_valid/cfg_ready writes max_text_bytes (reset 4096); write only idle.
// one byte per cycle sustained while s_axis_tready stays high. the parser
// registers a result in the cycle after the input transaction, it enters a
// four-entry queue, and m_axis shows it from the queue head.
// s_axis_tready drops only when the queue could not absorb results already
// in flight, so a stalled receiver stalls input after the queue fills.
// reset clears parse state to idle and empties the queue.
// ----------------------------------------------------------------------------
module ndef_text_record_extractor #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // start_of_record
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // text_byte, status, truncated
	output logic        m_axis_tlast,   // is_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import ntre_pkg::*;

	localparam int CW = $clog2(QueueDepth + 1);

	logic [15:0] max_q;
	logic        in_acc, res_valid, rd_en;
	result_t     res, head;
	logic [CW-1:0] count;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= 16'd4096;
		else if (cfg_valid) max_q <= cfg_data;
	end

	// one result may be in flight in the parser register
	assign s_axis_tready = ({1'b0, count} + (CW+1)'(res_valid)) < (CW+1)'(QueueDepth);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign rd_en         = m_axis_tvalid && m_axis_tready;

	ntre_parser u_parser (
		.clk, .arst_n, .in_valid(in_acc), .in_start(s_axis_tuser),
		.in_byte(s_axis_tdata), .max_text_bytes(max_q), .res_valid, .res
	);

	ntre_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk, .arst_n, .wr_en(res_valid), .wr_data(res), .count,
		.rd_valid(m_axis_tvalid), .rd_en, .rd_data(head)
	);

	assign m_axis_tdata = {5'd0, head.truncated, head.status, head.text_byte};
	assign m_axis_tlast = head.is_last;

endmodule

### bench/tb_ndef_text_record_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ndef_text_record_extractor
// self-checking bench: a directed table of records, then random records and
// noise under several text limits and idle patterns, each result compared
// with a behavioral model of the parser kept inside the bench
// ----------------------------------------------------------------------------
module tb_ndef_text_record_extractor;
	import ntre_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_TLEN, P_PLEN, P_IDLEN, P_TYPE, P_ID, P_STATUS, P_LANG, P_TEXT, P_DONE
	} phase_t;

	typedef struct {
		bit         sof;
		logic [7:0] b;
		bit         chk;
		result_t    res;
	} row_t;

	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	ndef_text_record_extractor dut (.*);

	// parser model state
	phase_t      ph;
	bit          sr_flag, il_flag, is_text;
	logic [2:0]  tnf;
	logic [7:0]  tlen, idlen;
	logic [31:0] plen, left;
	logic [15:0] emitted, text_limit;

	result_t     pending[$];
	int          errors;
	int          cycles;
	int          send_idle_pct;
	int          recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("ndef_text_record_extractor regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				report_mismatch("unexpected transaction", m_axis_tdata, 0);
			end else begin
				want = pending.pop_front();
				if (m_axis_tdata[7:0] !== want.text_byte)
					report_mismatch("text_byte", m_axis_tdata[7:0], want.text_byte);
				if (m_axis_tdata[9:8] !== want.status)
					report_mismatch("status", m_axis_tdata[9:8], want.status);
				if (m_axis_tlast !== want.is_last)
					report_mismatch("is_last", m_axis_tlast, want.is_last);
				if (m_axis_tdata[10] !== want.truncated)
					report_mismatch("truncated", m_axis_tdata[10], want.truncated);
			end
		end
	end

	function automatic result_t mk(logic [7:0] tb, logic [1:0] st, logic l, logic t);
		result_t r;
		r.text_byte = tb;
		r.status = st;
		r.is_last = l;
		r.truncated = t;
		return r;
	endfunction

	task automatic close_header(output bit has, output result_t r);
		if (plen != 0 && tnf == TNF_WKNOWN && is_text) begin
			ph = P_STATUS;
		end else begin
			ph = P_DONE;
			has = 1;
			r = mk(8'd0, ST_NOTTEXT, 1'b1, 1'b0);
		end
	endtask

	task automatic open_id(output bit has, output result_t r);
		if (idlen != 0) begin
			ph = P_ID;
			left = idlen;
		end else begin
			close_header(has, r);
		end
	endtask

	task automatic open_type(output bit has, output result_t r);
		if (tlen != 0) begin
			ph = P_TYPE;
			left = tlen;
		end else begin
			open_id(has, r);
		end
	endtask

	task automatic open_text(output bit has, output result_t r);
		if (plen == 0) begin
			ph = P_DONE;
			has = 1;
			r = mk(8'd0, ST_EMPTY, 1'b1, 1'b0);
		end else begin
			ph = P_TEXT;
		end
	endtask

	task automatic parse_byte(input bit sof, input logic [7:0] b, output bit has,
			output result_t r);
		logic [31:0] lang;
		has = 0;
		r = '0;
		if (sof) begin
			sr_flag = b[4];
			il_flag = b[3];
			tnf = b[2:0];
			tlen = 0;
			plen = 0;
			idlen = 0;
			is_text = 0;
			left = 0;
			emitted = 0;
			ph = P_TLEN;
			return;
		end
		case (ph)
			P_TLEN: begin
				tlen = b;
				left = sr_flag ? 1 : 4;
				ph = P_PLEN;
			end
			P_PLEN: begin
				plen = {plen[23:0], b};
				left--;
				if (left == 0) begin
					if (il_flag) ph = P_IDLEN;
					else open_type(has, r);
				end
			end
			P_IDLEN: begin
				idlen = b;
				open_type(has, r);
			end
			P_TYPE: begin
				if (left == tlen) is_text = (b == TEXT_TYPE && tlen == 1);
				left--;
				if (left == 0) open_id(has, r);
			end
			P_ID: begin
				left--;
				if (left == 0) close_header(has, r);
			end
			P_STATUS: begin
				lang = b & LANG_MASK;
				if (33'(lang) + 1 > 33'(plen)) begin
					ph = P_DONE;
					has = 1;
					r = mk(8'd0, ST_LANGLONG, 1'b1, 1'b0);
				end else begin
					plen = plen - 1 - lang;
					if (lang == 0) begin
						open_text(has, r);
					end else begin
						left = lang;
						ph = P_LANG;
					end
				end
			end
			P_LANG: begin
				left--;
				if (left == 0) open_text(has, r);
			end
			P_TEXT: begin
				plen--;
				emitted++;
				has = 1;
				if (plen == 0) begin
					ph = P_DONE;
					r = mk(b, ST_TEXT, 1'b1, 1'b0);
				end else if (emitted >= text_limit) begin
					ph = P_DONE;
					r = mk(b, ST_TEXT, 1'b1, 1'b1);
				end else begin
					r = mk(b, ST_TEXT, 1'b0, 1'b0);
				end
			end
			default: ;
		endcase
	endtask

	// drive one byte, wait for the transaction, then predict its result
	task automatic send_byte(input bit sof, input logic [7:0] b, input bit chk,
			input result_t want);
		bit has;
		result_t r;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= sof;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		parse_byte(sof, b, has, r);
		if (chk && (!has || r != want))
			report_mismatch("table row expectation", r, want);
		if (has) pending.push_back(r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		text_limit = v;
	endtask

	// one record, mostly well-formed text with random content
	task automatic random_record();
		bit sr, il;
		logic [2:0] tn;
		int tl, il_len, pl, lg, n, cut;
		logic [7:0] hdr;
		result_t z;
		z = '0;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				send_byte($urandom_range(0, 3) == 0, 8'($urandom), 0, z);
			return;
		end
		sr = $urandom_range(0, 3) != 0;
		il = $urandom_range(0, 2) == 0;
		tn = ($urandom_range(0, 7) == 0) ? 3'($urandom) : TNF_WKNOWN;
		tl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1;
		il_len = $urandom_range(0, 3);
		lg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
		pl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : lg + 1 + $urandom_range(0, 20);
		hdr = {3'($urandom), sr, il, tn};
		send_byte(1, hdr, 0, z);
		send_byte(0, 8'(tl), 0, z);
		if (!sr) begin
			send_byte(0, 8'(pl >> 24), 0, z);
			send_byte(0, 8'(pl >> 16), 0, z);
			send_byte(0, 8'(pl >> 8), 0, z);
		end
		send_byte(0, 8'(pl), 0, z);
		if (il) send_byte(0, 8'(il_len), 0, z);
		for (int i = 0; i < tl; i++)
			send_byte(0, ($urandom_range(0, 7) == 0) ? 8'($urandom) : TEXT_TYPE, 0, z);
		if (il)
			for (int i = 0; i < il_len; i++) send_byte(0, 8'($urandom), 0, z);
		n = pl;
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
		for (int i = 0; i < cut; i++) begin
			if (i == 0) send_byte(0, {2'($urandom), 6'(lg)}, 0, z);
			else send_byte(0, 8'($urandom), 0, z);
		end
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) send_byte(0, 8'($urandom), 0, z);
	endtask

	row_t rows[$];
	logic [15:0] limits[6];

	initial begin
		result_t z;
		z = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		errors = 0;
		cycles = 0;
		send_idle_pct = 16;
		recv_idle_pct = 66;
		ph = P_IDLE;
		sr_flag = 0; il_flag = 0; is_text = 0;
		tnf = 0; tlen = 0; idlen = 0; plen = 0; left = 0; emitted = 0;
		text_limit = 16'd4096;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short text record, language "e", text "hi"
		rows = '{
			'{1, 8'hD1, 0, z}, '{0, 8'h01, 0, z}, '{0, 8'h04, 0, z}, '{0, 8'h54, 0, z},
			'{0, 8'h01, 0, z}, '{0, 8'h65, 0, z}, '{0, 8'h68, 0, z},
			'{0, 8'h69, 1, mk(8'h69, ST_TEXT, 1, 0)},
			// byte after the payload is ignored
			'{0, 8'hFF, 0, z},
			// tnf 2 is not text
			'{1, 8'h12, 0, z}, '{0, 8'h01, 0, z}, '{0, 8'h01, 0, z},
			'{0, 8'h54, 1, mk(8'h00, ST_NOTTEXT, 1, 0)},
			// language length overruns the payload
			'{1, 8'hD1, 0, z}, '{0, 8'h01, 0, z}, '{0, 8'h02, 0, z}, '{0, 8'h54, 0, z},
			'{0, 8'hFF, 1, mk(8'h00, ST_LANGLONG, 1, 0)},
			// empty text on the status byte
			'{1, 8'hD1, 0, z}, '{0, 8'h01, 0, z}, '{0, 8'h01, 0, z}, '{0, 8'h54, 0, z},
			'{0, 8'h00, 1, mk(8'h00, ST_EMPTY, 1, 0)},
			// long record with id, start abandons it in mid-record once
			'{1, 8'h09, 0, z}, '{0, 8'h01, 0, z}, '{1, 8'h09, 0, z}, '{0, 8'h01, 0, z},
			'{0, 8'h00, 0, z}, '{0, 8'h00, 0, z}, '{0, 8'h00, 0, z}, '{0, 8'h02, 0, z},
			'{0, 8'h01, 0, z}, '{0, 8'h54, 0, z}, '{0, 8'hFF, 0, z}, '{0, 8'h00, 0, z},
			'{0, 8'h00, 1, mk(8'h00, ST_TEXT, 1, 0)}
		};
		foreach (rows[i]) send_byte(rows[i].sof, rows[i].b, rows[i].chk, rows[i].res);

		limits = '{16'd1, 16'd65535, 16'd3, 16'd4096, 16'($urandom_range(1, 12)), 16'd2};
		for (int p = 0; p < 6; p++) begin
			set_limit(limits[p]);
			case (p / 2)
				0: begin send_idle_pct = 16; recv_idle_pct = 66; end
				1: begin send_idle_pct = 66; recv_idle_pct = 16; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int k = 0; k < 16; k++) begin
				random_record();
				// hold off until the pipeline has emptied
				if (k == 8) drain();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("ndef_text_record_extractor regression: pass");
		end else begin
			$display("ndef_text_record_extractor regression: fail");
		end
		$finish;
	end

endmodule

### files.f
design/ntre_pkg.sv
design/ntre_parser.sv
design/ntre_fifo.sv
design/ndef_text_record_extractor.sv
bench/tb_ndef_text_record_extractor.sv
